// ----- src/yc2rgb_pkg.sv -----
`timescale 1ns / 1ps

package yc2rgb_pkg;

  // sample and bus widths
  localparam int PIX_W  = 8;
  localparam int IN_W   = 4 * PIX_W;
  localparam int OUT_W  = 6 * PIX_W;

  // width of one weighted term after the shift, and of a channel before clamping
  localparam int TERM_W = 10;
  localparam int CHAN_W = 11;
  localparam int PROD_W = 18;

  // integer weights, scaled by 256
  localparam logic signed [PROD_W-1:0] K_LUMA     = 18'sd298;
  localparam logic signed [PROD_W-1:0] K_RED_CR   = 18'sd409;
  localparam logic signed [PROD_W-1:0] K_GREEN_CR = 18'sd208;
  localparam logic signed [PROD_W-1:0] K_GREEN_CB = 18'sd100;
  localparam logic signed [PROD_W-1:0] K_BLUE_CB  = 18'sd516;

  localparam logic signed [8:0]        LUMA_OFS   = 9'sd16;
  localparam logic signed [8:0]        CHROMA_OFS = 9'sd128;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = 18'sd128;
  localparam logic [PIX_W-1:0]         PIX_MAX    = 8'hFF;

  typedef logic signed [TERM_W-1:0] term_t;

  // chroma contributions shared by both pixels of a pair
  typedef struct packed {
    term_t red;
    term_t green;
    term_t blue;
  } chroma_terms_t;

  // (298*(y-16)) >> 8, floor shift
  function automatic term_t luma_term(input logic [PIX_W-1:0] y);
    logic signed [8:0]        d;
    logic signed [PROD_W-1:0] p;
    d = $signed({1'b0, y}) - LUMA_OFS;
    p = PROD_W'(d) * K_LUMA;
    return TERM_W'(p >>> 8);
  endfunction

  // (k*(c-128)+128) >> 8, floor shift
  function automatic term_t chroma_term(input logic signed [PROD_W-1:0] k,
                                        input logic [PIX_W-1:0]         c);
    logic signed [8:0]        d;
    logic signed [PROD_W-1:0] p;
    d = $signed({1'b0, c}) - CHROMA_OFS;
    p = PROD_W'(d) * k + ROUND_HALF;
    return TERM_W'(p >>> 8);
  endfunction

  // clamp a channel to 0..255
  function automatic logic [PIX_W-1:0] sat8(input logic signed [CHAN_W-1:0] v);
    logic [PIX_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > 11'sd255) begin
      r = PIX_MAX;
    end else begin
      r = v[PIX_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- src/yc2rgb_chroma.sv -----
`timescale 1ns / 1ps

module yc2rgb_chroma (
  input  logic [yc2rgb_pkg::PIX_W-1:0] chroma_blue,
  input  logic [yc2rgb_pkg::PIX_W-1:0] chroma_red,
  output yc2rgb_pkg::chroma_terms_t    terms
);

  yc2rgb_pkg::term_t green_cr;
  yc2rgb_pkg::term_t green_cb;

  // green sums its two separately rounded terms
  always_comb begin
    green_cr    = yc2rgb_pkg::chroma_term(yc2rgb_pkg::K_GREEN_CR, chroma_red);
    green_cb    = yc2rgb_pkg::chroma_term(yc2rgb_pkg::K_GREEN_CB, chroma_blue);
    terms.red   = yc2rgb_pkg::chroma_term(yc2rgb_pkg::K_RED_CR, chroma_red);
    terms.green = green_cr + green_cb;
    terms.blue  = yc2rgb_pkg::chroma_term(yc2rgb_pkg::K_BLUE_CB, chroma_blue);
  end

endmodule

// ----- src/yc2rgb_pixel.sv -----
`timescale 1ns / 1ps

module yc2rgb_pixel (
  input  logic [yc2rgb_pkg::PIX_W-1:0] luma,
  input  yc2rgb_pkg::chroma_terms_t    terms,
  output logic [yc2rgb_pkg::PIX_W-1:0] red,
  output logic [yc2rgb_pkg::PIX_W-1:0] green,
  output logic [yc2rgb_pkg::PIX_W-1:0] blue
);

  yc2rgb_pkg::term_t                     l;
  logic signed [yc2rgb_pkg::CHAN_W-1:0] red_sum;
  logic signed [yc2rgb_pkg::CHAN_W-1:0] green_sum;
  logic signed [yc2rgb_pkg::CHAN_W-1:0] blue_sum;

  // scaled luma plus or minus the chroma terms, then clamp each channel
  always_comb begin
    l         = yc2rgb_pkg::luma_term(luma);
    red_sum   = yc2rgb_pkg::CHAN_W'(l) + yc2rgb_pkg::CHAN_W'(terms.red);
    green_sum = yc2rgb_pkg::CHAN_W'(l) - yc2rgb_pkg::CHAN_W'(terms.green);
    blue_sum  = yc2rgb_pkg::CHAN_W'(l) + yc2rgb_pkg::CHAN_W'(terms.blue);
    red       = yc2rgb_pkg::sat8(red_sum);
    green     = yc2rgb_pkg::sat8(green_sum);
    blue      = yc2rgb_pkg::sat8(blue_sum);
  end

endmodule

// ----- src/ycbcr_pair_to_rgb.sv -----
// an accepted pair is held in the input register, then in the result register, which drives m_tvalid
// throughput: one pixel pair per cycle while m_tready stays high, set by the input and result registers
// the chroma products and luma products are formed between those two registers
// reset (rst, synchronous) clears both valid flags; data registers are not reset
`timescale 1ns / 1ps

module ycbcr_pair_to_rgb (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // luma_first, luma_second, chroma_blue, chroma_red (8 bits each)
  input  logic [yc2rgb_pkg::IN_W-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // red_first, green_first, blue_first, red_second, green_second, blue_second
  output logic [yc2rgb_pkg::OUT_W-1:0] m_tdata
);

  localparam int W = yc2rgb_pkg::PIX_W;

  logic                          in_valid;
  logic [yc2rgb_pkg::IN_W-1:0]  in_data;
  logic                          out_valid;
  logic [yc2rgb_pkg::OUT_W-1:0] out_data;
  logic [yc2rgb_pkg::OUT_W-1:0] out_data_next;
  logic                          out_free;
  logic                          in_advance;

  yc2rgb_pkg::chroma_terms_t terms;
  logic [W-1:0] red_first, green_first, blue_first;
  logic [W-1:0] red_second, green_second, blue_second;

  // handshake: result register frees when empty or taken downstream
  assign out_free   = !out_valid || m_tready;
  assign in_advance = in_valid && out_free;
  assign s_tready   = !in_valid || in_advance;
  assign m_tvalid   = out_valid;
  assign m_tdata    = out_data;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data <= s_tdata;
    end
  end

  // shared chroma terms
  yc2rgb_chroma u_chroma (
    .chroma_blue (in_data[2*W +: W]),
    .chroma_red  (in_data[3*W +: W]),
    .terms       (terms)
  );

  // left and right pixels
  yc2rgb_pixel u_pixel_first (
    .luma  (in_data[0 +: W]),
    .terms (terms),
    .red   (red_first),
    .green (green_first),
    .blue  (blue_first)
  );

  yc2rgb_pixel u_pixel_second (
    .luma  (in_data[W +: W]),
    .terms (terms),
    .red   (red_second),
    .green (green_second),
    .blue  (blue_second)
  );

  assign out_data_next = {blue_second, green_second, red_second,
                          blue_first, green_first, red_first};

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_advance) begin
      out_data <= out_data_next;
    end
  end

`ifndef SYNTH
  // an input transfer never lands on a full, stalled pipeline
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> !(in_valid && out_valid && !m_tready))
    else $error("input transfer while pipeline full");

  // a held item moves on when the result register is empty
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !out_valid) |=> out_valid)
    else $error("item did not reach result register");

  // an empty input register always takes a transfer
  assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("ready low with empty input register");

  // reset empties the pipeline
  assert property (@(posedge clk) rst |=> (!in_valid && !m_tvalid))
    else $error("valid flags not cleared by reset");
`endif

endmodule
